// File: rtl/core/c_subset_lexer_macros.svh
// Assertion macros for the lexer port checker.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CSL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer port check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexer port check failed");

`endif

// File: rtl/core/csl_pkg.sv
package csl_pkg;

  localparam int MAX_LEXEME_DEF = 32;
  localparam int NUM_KW = 7;

  // Token kinds.
  localparam logic [5:0] K_PLUS    = 6'd0;
  localparam logic [5:0] K_MINUS   = 6'd1;
  localparam logic [5:0] K_DIV     = 6'd2;
  localparam logic [5:0] K_MULT    = 6'd3;
  localparam logic [5:0] K_MOD     = 6'd4;
  localparam logic [5:0] K_XOR     = 6'd5;
  localparam logic [5:0] K_SEMI    = 6'd6;
  localparam logic [5:0] K_COMMA   = 6'd7;
  localparam logic [5:0] K_LBRACE  = 6'd8;
  localparam logic [5:0] K_RBRACE  = 6'd9;
  localparam logic [5:0] K_LPAREN  = 6'd10;
  localparam logic [5:0] K_RPAREN  = 6'd11;
  localparam logic [5:0] K_EQ      = 6'd12;
  localparam logic [5:0] K_ASSIGN  = 6'd13;
  localparam logic [5:0] K_LE      = 6'd14;
  localparam logic [5:0] K_LSHIFT  = 6'd15;
  localparam logic [5:0] K_LT      = 6'd16;
  localparam logic [5:0] K_GE      = 6'd17;
  localparam logic [5:0] K_RSHIFT  = 6'd18;
  localparam logic [5:0] K_GT      = 6'd19;
  localparam logic [5:0] K_NEQ     = 6'd20;
  localparam logic [5:0] K_NOT     = 6'd21;
  localparam logic [5:0] K_ANDL    = 6'd22;
  localparam logic [5:0] K_ANDB    = 6'd23;
  localparam logic [5:0] K_ORL     = 6'd24;
  localparam logic [5:0] K_ORB     = 6'd25;
  localparam logic [5:0] K_LCOM    = 6'd26;
  localparam logic [5:0] K_RCOM    = 6'd27;
  localparam logic [5:0] K_KW0     = 6'd28;
  localparam logic [5:0] K_IDENT   = 6'd35;
  localparam logic [5:0] K_INTEGER = 6'd36;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_STAR, M_EQ, M_LT, M_GT,
    M_BANG, M_AMP, M_BAR, M_LINE, M_NAME, M_NUM
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RD, ST_LD, ST_TAIL
  } state_t;

  // What a pending mode does with the next byte.
  typedef struct packed {
    logic       consumed;
    mode_t      mode;
    logic       op_valid;
    logic [5:0] op_kind;
    logic       append;
    logic       replay;
    logic       replay_int;
  } resolve_t;

  // What a fresh byte does from the idle mode.
  typedef struct packed {
    logic       op_valid;
    logic [5:0] op_kind;
    mode_t      mode;
    logic       word;
  } start_t;

  // One result item, token_kind in the lowest bits.
  typedef struct packed {
    logic       truncated;
    logic       token_end;
    logic       has_byte;
    logic [7:0] lexeme_byte;
    logic [5:0] token_kind;
  } res_item_t;

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0: n = 3'd2;
      3'd1: n = 3'd4;
      3'd2: n = 3'd3;
      3'd3: n = 3'd5;
      3'd4: n = 3'd3;
      3'd5: n = 3'd4;
      3'd6: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Character pos of keyword k; zero beyond its end.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [4:0][7:0] txt;
    case (k)
      3'd0: txt = {8'h00, 8'h00, 8'h00, "f", "i"};
      3'd1: txt = {8'h00, "e", "s", "l", "e"};
      3'd2: txt = {8'h00, 8'h00, "r", "o", "f"};
      3'd3: txt = {"e", "l", "i", "h", "w"};
      3'd4: txt = {8'h00, 8'h00, "t", "n", "i"};
      3'd5: txt = {8'h00, "r", "a", "h", "c"};
      3'd6: txt = {"t", "a", "o", "l", "f"};
      default: txt = '0;
    endcase
    return (pos <= 3'd4) ? txt[pos] : 8'h00;
  endfunction

  function automatic start_t start_decode(input logic [7:0] c);
    start_t s;
    s = '0;
    s.mode = M_IDLE;
    case (c)
      "+": begin s.op_valid = 1'b1; s.op_kind = K_PLUS; end
      "-": begin s.op_valid = 1'b1; s.op_kind = K_MINUS; end
      "%": begin s.op_valid = 1'b1; s.op_kind = K_MOD; end
      "^": begin s.op_valid = 1'b1; s.op_kind = K_XOR; end
      ";": begin s.op_valid = 1'b1; s.op_kind = K_SEMI; end
      ",": begin s.op_valid = 1'b1; s.op_kind = K_COMMA; end
      "{": begin s.op_valid = 1'b1; s.op_kind = K_LBRACE; end
      "}": begin s.op_valid = 1'b1; s.op_kind = K_RBRACE; end
      "(": begin s.op_valid = 1'b1; s.op_kind = K_LPAREN; end
      ")": begin s.op_valid = 1'b1; s.op_kind = K_RPAREN; end
      "/": s.mode = M_SLASH;
      "*": s.mode = M_STAR;
      "=": s.mode = M_EQ;
      "<": s.mode = M_LT;
      ">": s.mode = M_GT;
      "!": s.mode = M_BANG;
      "&": s.mode = M_AMP;
      "|": s.mode = M_BAR;
      default: begin
        if (is_name_char(c)) begin
          s.word = 1'b1;
          s.mode = M_NAME;
        end else if (is_digit(c)) begin
          s.word = 1'b1;
          s.mode = M_NUM;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/csl_decode.sv
module csl_decode #(
  parameter int MAX_LEXEME = csl_pkg::MAX_LEXEME_DEF
) (
  input  csl_pkg::mode_t                     mode,
  input  logic [7:0]                         c,
  input  logic [$clog2(MAX_LEXEME+1)-1:0]    len,
  input  logic                               ovf,
  input  logic [csl_pkg::NUM_KW-1:0]         kw_mask,
  output csl_pkg::resolve_t                  res
);
  import csl_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);

  logic       kw_hit;
  logic [5:0] kw_kind;

  // The candidate mask has followed the name byte by byte; only the length is left.
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_mask[k] && len == LEN_W'(kw_len(3'(k)))) begin
        kw_hit  = 1'b1;
        kw_kind = K_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    res = '0;
    res.mode = M_IDLE;
    case (mode)
      M_SLASH: begin
        if (c == "/") begin
          res.consumed = 1'b1;
          res.mode = M_LINE;
        end else if (c == "*") begin
          res.consumed = 1'b1;
          res.op_valid = 1'b1;
          res.op_kind = K_LCOM;
        end else begin
          res.op_valid = 1'b1;
          res.op_kind = K_DIV;
        end
      end
      M_STAR: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "/");
        res.op_kind = (c == "/") ? K_RCOM : K_MULT;
      end
      M_EQ: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "=");
        res.op_kind = (c == "=") ? K_EQ : K_ASSIGN;
      end
      M_LT: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "=") || (c == "<");
        res.op_kind = (c == "=") ? K_LE : ((c == "<") ? K_LSHIFT : K_LT);
      end
      M_GT: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "=") || (c == ">");
        res.op_kind = (c == "=") ? K_GE : ((c == ">") ? K_RSHIFT : K_GT);
      end
      M_BANG: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "=");
        res.op_kind = (c == "=") ? K_NEQ : K_NOT;
      end
      M_AMP: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "&");
        res.op_kind = (c == "&") ? K_ANDL : K_ANDB;
      end
      M_BAR: begin
        res.op_valid = 1'b1;
        res.consumed = (c == "|");
        res.op_kind = (c == "|") ? K_ORL : K_ORB;
      end
      M_LINE: begin
        res.consumed = 1'b1;
        res.mode = (c == 8'h0A) ? M_IDLE : M_LINE;
      end
      M_NAME: begin
        if (is_name_char(c) || is_digit(c)) begin
          res.consumed = 1'b1;
          res.append = 1'b1;
          res.mode = M_NAME;
        end else if (kw_hit && !ovf) begin
          res.op_valid = 1'b1;
          res.op_kind = kw_kind;
        end else begin
          res.replay = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          res.consumed = 1'b1;
          res.append = 1'b1;
          res.mode = M_NUM;
        end else begin
          res.replay = 1'b1;
          res.replay_int = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/c_subset_lexer.sv
// Byte-serial lexer for a small C subset. Source bytes arrive on the s_ stream, one per
// transaction, with s_tuser set to mark end of text; tokens leave on the m_ stream, one
// result per transaction, with m_tlast on the final result that an input byte causes.
// A byte that a pending mode consumes is taken whenever the output register is free.
// Any other byte, whether it arrives in the idle mode or only closes a pending
// operator or keyword, then passes through the tail state to start afresh, and that
// state also waits for the output register when the byte gives an operator at once.
// An identifier or integer of n buffered bytes (at most MAX_LEXEME) is replayed from
// the single-port lexeme memory after the ending byte is taken, with a read state and
// an output state per byte, during which no input is taken. The lexeme memory needs
// no clearing pass after reset: only entries below the current length are ever read.
module c_subset_lexer #(
  parameter int MAX_LEXEME = csl_pkg::MAX_LEXEME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [5:0] token_kind, [13:6] lexeme_byte, [14] has_byte,
                                 // [15] token_end, [16] truncated, [23:17] zero
  output logic        m_tlast    // last
);
  import csl_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int AW    = $clog2(MAX_LEXEME);

  state_t              state, state_next;
  mode_t               mode, mode_next;
  logic [LEN_W-1:0]    len, len_next;
  logic                ovf, ovf_next;
  logic [NUM_KW-1:0]   kw_mask, mask_next;
  logic [AW-1:0]       idx, idx_next;
  logic [7:0]          pend_c, pend_c_next;
  logic                pend_start, pend_start_next;
  logic                pend_emit, pend_emit_next;
  logic                rep_int, rep_int_next;

  logic                out_valid;
  res_item_t           out_item;
  logic                out_last;
  logic                out_free;
  logic                load;
  res_item_t           load_item;
  logic                load_last;

  logic [7:0]          lex_mem [MAX_LEXEME];
  logic [7:0]          mem_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;

  logic                acc;
  logic [7:0]          dec_c;
  resolve_t            dec;
  start_t              in_sd, tail_sd;
  logic                last_byte;

  // One step of the candidate keyword mask for byte c at position pos.
  function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] m,
                                                 input logic [LEN_W-1:0] pos,
                                                 input logic [7:0] c);
    logic [NUM_KW-1:0] r;
    for (int k = 0; k < NUM_KW; k++) begin
      r[k] = m[k] && (pos < LEN_W'(kw_len(3'(k)))) && (kw_char(3'(k), pos[2:0]) == c);
    end
    return r;
  endfunction

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;
  assign dec_c    = s_tuser ? 8'h00 : s_tdata;
  assign in_sd    = start_decode(s_tdata);
  assign tail_sd  = start_decode(pend_c);
  assign last_byte = (LEN_W'(idx) + LEN_W'(1)) == len;

  csl_decode #(.MAX_LEXEME(MAX_LEXEME)) u_decode (
    .mode    (mode),
    .c       (dec_c),
    .len     (len),
    .ovf     (ovf),
    .kw_mask (kw_mask),
    .res     (dec)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (dec.replay) begin
            state_next = ST_RD;
          end else if (!s_tuser && !dec.consumed) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_RD: state_next = ST_LD;
      ST_LD: begin
        if (out_free) begin
          if (last_byte) begin
            state_next = pend_start ? ST_TAIL : ST_IDLE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_TAIL: begin
        if (!tail_sd.op_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    load            = 1'b0;
    load_item       = '0;
    load_last       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = len[AW-1:0];
    mem_wdata       = s_tdata;
    mode_next       = mode;
    len_next        = len;
    ovf_next        = ovf;
    mask_next       = kw_mask;
    idx_next        = idx;
    pend_c_next     = pend_c;
    pend_start_next = pend_start;
    pend_emit_next  = pend_emit;
    rep_int_next    = rep_int;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          mode_next       = s_tuser ? M_IDLE : dec.mode;
          pend_c_next     = s_tdata;
          pend_start_next = !s_tuser && !dec.consumed;
          pend_emit_next  = in_sd.op_valid;
          rep_int_next    = dec.replay_int;
          idx_next        = '0;
          if (dec.op_valid) begin
            load                 = 1'b1;
            load_item.token_kind = dec.op_kind;
            load_item.token_end  = 1'b1;
            load_last            = !(pend_start_next && in_sd.op_valid);
          end
          if (dec.append) begin
            if (len < LEN_W'(MAX_LEXEME)) begin
              mem_we    = 1'b1;
              len_next  = len + LEN_W'(1);
              mask_next = kw_step(kw_mask, len, dec_c);
            end else begin
              ovf_next = 1'b1;
            end
          end
          // A keyword, a dropped comment or an operator leaves no lexeme behind.
          if (!dec.replay && !dec.append) begin
            len_next = '0;
            ovf_next = 1'b0;
          end
        end
      end
      ST_RD: mem_re = 1'b1;
      ST_LD: begin
        if (out_free) begin
          load                  = 1'b1;
          load_item.token_kind  = rep_int ? K_INTEGER : K_IDENT;
          load_item.lexeme_byte = mem_q;
          load_item.has_byte    = 1'b1;
          load_item.token_end   = last_byte;
          load_item.truncated   = ovf;
          load_last             = last_byte && !(pend_start && pend_emit);
          if (last_byte) begin
            len_next = '0;
            ovf_next = 1'b0;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      ST_TAIL: begin
        if (!tail_sd.op_valid || out_free) begin
          pend_start_next = 1'b0;
          mode_next       = tail_sd.mode;
          if (tail_sd.op_valid) begin
            load                 = 1'b1;
            load_item.token_kind = tail_sd.op_kind;
            load_item.token_end  = 1'b1;
            load_last            = 1'b1;
          end
          if (tail_sd.word) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = pend_c;
            len_next  = LEN_W'(1);
            ovf_next  = 1'b0;
            mask_next = kw_step('1, '0, pend_c);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= M_IDLE;
      len        <= '0;
      ovf        <= 1'b0;
      pend_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      len        <= len_next;
      ovf        <= ovf_next;
      pend_start <= pend_start_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kw_mask   <= mask_next;
    idx       <= idx_next;
    pend_c    <= pend_c_next;
    pend_emit <= pend_emit_next;
    rep_int   <= rep_int_next;
    if (load) begin
      out_item <= load_item;
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lex_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= lex_mem[idx];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_item};
  assign m_tlast  = out_last;

endmodule

// File: rtl/core/csl_checker.sv
`include "c_subset_lexer_macros.svh"

module csl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);
  import csl_pkg::*;

  // A stalled result holds its contents.
  `CSL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  `CSL_ASSERT_IMP(a_kind_range, m_tvalid, m_tdata[5:0] <= K_INTEGER)

  // Only identifiers and integers carry lexeme bytes.
  `CSL_ASSERT_IMP(a_byte_kind, m_tvalid && m_tdata[14],
                  m_tdata[5:0] == K_IDENT || m_tdata[5:0] == K_INTEGER)

  // A token without a lexeme is a single complete result.
  `CSL_ASSERT_IMP(a_op_shape, m_tvalid && !m_tdata[14],
                  m_tdata[15] && m_tdata[13:6] == 8'd0 && !m_tdata[16])

  // The final result of a byte always closes a token.
  `CSL_ASSERT_IMP(a_last_closes, m_tvalid && m_tlast, m_tdata[15])

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);

// File: tb/sv/c_subset_lexer_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the lexer, works out the tokens that each accepted
// source byte must produce and compares every result transaction with the oldest
// token still owed.
module c_subset_lexer_checker #(
  parameter int MAX_LEXEME = csl_pkg::MAX_LEXEME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] end_of_input
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [5:0] token_kind, [13:6] lexeme_byte, [14] has_byte,
                                 // [15] token_end, [16] truncated, [23:17] zero
  input  logic        m_tlast,   // last
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);

  import csl_pkg::*;

  localparam logic [5:0] KW_IF    = K_KW0 + 6'd0;
  localparam logic [5:0] KW_ELSE  = K_KW0 + 6'd1;
  localparam logic [5:0] KW_FOR   = K_KW0 + 6'd2;
  localparam logic [5:0] KW_WHILE = K_KW0 + 6'd3;
  localparam logic [5:0] KW_INT   = K_KW0 + 6'd4;
  localparam logic [5:0] KW_CHAR  = K_KW0 + 6'd5;
  localparam logic [5:0] KW_FLOAT = K_KW0 + 6'd6;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] lex;
    logic       has;
    logic       tend;
    logic       trunc;
    logic       tlast;
  } token_t;

  mode_t      lex_state = M_IDLE;
  logic [7:0] word_buf [0:MAX_LEXEME-1];
  int         word_len = 0;
  bit         word_over = 1'b0;

  token_t     step_tokens[$];
  token_t     expected_tokens[$];
  int         error_count = 0;
  int         result_count = 0;

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_token(input logic [5:0] kind, input logic [7:0] lex,
                                     input logic has, input logic tend,
                                     input logic trunc);
    token_t t;
    t.kind = kind;
    t.lex = lex;
    t.has = has;
    t.tend = tend;
    t.trunc = trunc;
    t.tlast = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void push_op(input logic [5:0] kind);
    push_token(kind, 8'h00, 1'b0, 1'b1, 1'b0);
  endfunction

  function automatic void stash_char(input logic [7:0] c);
    if (word_len < MAX_LEXEME) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      word_over = 1'b1;
    end
  endfunction

  // Returns the keyword kind for a short name, or K_IDENT when it is none.
  function automatic logic [5:0] keyword_kind(input int len, input logic [39:0] w);
    if (len == 2 && w[15:0] == "if") return KW_IF;
    if (len == 4 && w[31:0] == "else") return KW_ELSE;
    if (len == 3 && w[23:0] == "for") return KW_FOR;
    if (len == 5 && w[39:0] == "while") return KW_WHILE;
    if (len == 3 && w[23:0] == "int") return KW_INT;
    if (len == 4 && w[31:0] == "char") return KW_CHAR;
    if (len == 5 && w[39:0] == "float") return KW_FLOAT;
    return K_IDENT;
  endfunction

  function automatic void close_word(input logic [5:0] kind);
    logic [39:0] w;
    logic [5:0]  kw;
    int          i;
    kw = K_IDENT;
    if (kind == K_IDENT && !word_over && word_len <= 5) begin
      w = '0;
      for (i = 0; i < word_len; i++)
        w = {w[31:0], word_buf[i]};
      kw = keyword_kind(word_len, w);
    end
    if (kw != K_IDENT) begin
      push_op(kw);
      word_len = 0;
    end else begin
      for (i = 0; i < word_len; i++)
        push_token(kind, word_buf[i], 1'b1, i + 1 == word_len, word_over);
      word_len = 0;
      word_over = 1'b0;
    end
  endfunction

  // Settles a pending mode with byte c; returns 1 when c has been used up.
  function automatic bit settle_pending(input logic [7:0] c);
    case (lex_state)
      M_SLASH: begin
        lex_state = M_IDLE;
        if (c == "/") begin
          lex_state = M_LINE;
          return 1'b1;
        end
        if (c == "*") begin
          push_op(K_LCOM);
          return 1'b1;
        end
        push_op(K_DIV);
        return 1'b0;
      end
      M_STAR: begin
        lex_state = M_IDLE;
        if (c == "/") begin
          push_op(K_RCOM);
          return 1'b1;
        end
        push_op(K_MULT);
        return 1'b0;
      end
      M_EQ: begin
        lex_state = M_IDLE;
        if (c == "=") begin
          push_op(K_EQ);
          return 1'b1;
        end
        push_op(K_ASSIGN);
        return 1'b0;
      end
      M_LT: begin
        lex_state = M_IDLE;
        if (c == "=") begin
          push_op(K_LE);
          return 1'b1;
        end
        if (c == "<") begin
          push_op(K_LSHIFT);
          return 1'b1;
        end
        push_op(K_LT);
        return 1'b0;
      end
      M_GT: begin
        lex_state = M_IDLE;
        if (c == "=") begin
          push_op(K_GE);
          return 1'b1;
        end
        if (c == ">") begin
          push_op(K_RSHIFT);
          return 1'b1;
        end
        push_op(K_GT);
        return 1'b0;
      end
      M_BANG: begin
        lex_state = M_IDLE;
        if (c == "=") begin
          push_op(K_NEQ);
          return 1'b1;
        end
        push_op(K_NOT);
        return 1'b0;
      end
      M_AMP: begin
        lex_state = M_IDLE;
        if (c == "&") begin
          push_op(K_ANDL);
          return 1'b1;
        end
        push_op(K_ANDB);
        return 1'b0;
      end
      M_BAR: begin
        lex_state = M_IDLE;
        if (c == "|") begin
          push_op(K_ORL);
          return 1'b1;
        end
        push_op(K_ORB);
        return 1'b0;
      end
      M_LINE: begin
        if (c == 8'h0A) lex_state = M_IDLE;
        return 1'b1;
      end
      M_NAME: begin
        if (is_word_char(c) || is_num_char(c)) begin
          stash_char(c);
          return 1'b1;
        end
        lex_state = M_IDLE;
        close_word(K_IDENT);
        return 1'b0;
      end
      M_NUM: begin
        if (is_num_char(c)) begin
          stash_char(c);
          return 1'b1;
        end
        lex_state = M_IDLE;
        close_word(K_INTEGER);
        return 1'b0;
      end
      default: begin
        lex_state = M_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void open_token(input logic [7:0] c);
    case (c)
      "+": push_op(K_PLUS);
      "-": push_op(K_MINUS);
      "%": push_op(K_MOD);
      "^": push_op(K_XOR);
      ";": push_op(K_SEMI);
      ",": push_op(K_COMMA);
      "{": push_op(K_LBRACE);
      "}": push_op(K_RBRACE);
      "(": push_op(K_LPAREN);
      ")": push_op(K_RPAREN);
      "/": lex_state = M_SLASH;
      "*": lex_state = M_STAR;
      "=": lex_state = M_EQ;
      "<": lex_state = M_LT;
      ">": lex_state = M_GT;
      "!": lex_state = M_BANG;
      "&": lex_state = M_AMP;
      "|": lex_state = M_BAR;
      default: begin
        if (is_word_char(c) || is_num_char(c)) begin
          word_len = 0;
          word_over = 1'b0;
          stash_char(c);
          lex_state = is_num_char(c) ? M_NUM : M_NAME;
        end
      end
    endcase
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    token_t t;
    int     i;
    step_tokens.delete();
    if (eoi) begin
      void'(settle_pending(8'h00));
      lex_state = M_IDLE;
      word_len = 0;
      word_over = 1'b0;
    end else if (!settle_pending(c)) begin
      open_token(c);
    end
    for (i = 0; i < step_tokens.size(); i++) begin
      t = step_tokens[i];
      t.tlast = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  always @(posedge clk) begin : monitor
    token_t want;
    bit     bad;
    if (rst) begin
      lex_state = M_IDLE;
      word_len = 0;
      word_over = 1'b0;
      expected_tokens.delete();
    end else begin
      // Results leave a register, so none can stem from a byte taken at this edge.
      if (m_tvalid && m_tready) begin
        result_count++;
        if (expected_tokens.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%t: result with no token owed: tdata %h tlast %b",
                     $realtime, m_tdata, m_tlast);
        end else begin
          want = expected_tokens.pop_front();
          bad = (m_tdata[5:0] !== want.kind) || (m_tdata[13:6] !== want.lex) ||
                (m_tdata[14] !== want.has) || (m_tdata[15] !== want.tend) ||
                (m_tdata[16] !== want.trunc) || (m_tdata[23:17] !== 7'd0) ||
                (m_tlast !== want.tlast);
          if (bad) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%t: token mismatch: expected kind %0d byte %h has %b end %b %s",
                       $realtime, want.kind, want.lex, want.has, want.tend, "");
              $display("    expected trunc %b last %b", want.trunc, want.tlast);
              $display("    got kind %0d byte %h has %b end %b trunc %b pad %h last %b",
                       m_tdata[5:0], m_tdata[13:6], m_tdata[14], m_tdata[15],
                       m_tdata[16], m_tdata[23:17], m_tlast);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_tokens(s_tdata, s_tuser);
    end
    fail_count <= error_count;
    pending_count <= expected_tokens.size();
    checked_count <= result_count;
  end

endmodule

// File: tb/sv/c_subset_lexer_test.sv
`timescale 1ns / 100ps

module c_subset_lexer_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 280;
  localparam int QUIET_FROM  = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tuser = 1'b0;    // [0] end_of_input
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [5:0] token_kind, [13:6] lexeme_byte, [14] has_byte,
                                  // [15] token_end, [16] truncated, [23:17] zero
  logic        m_tlast;

  int fail_count;
  int pending_count;
  int checked_count;
  bit quiet = 1'b0;
  int sent_items = 0;
  int long_words = 0;

  always #5 clk = ~clk;

  c_subset_lexer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  c_subset_lexer_checker #(
    .MAX_LEXEME (csl_pkg::MAX_LEXEME_DEF)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Offers one byte, after an occasional gap, returns at the edge that takes it and
  // counts it.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string t);
    int i;
    for (i = 0; i < t.len(); i++) begin
      send_item(t[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] word_char(input bit digits_ok);
    int pick;
    pick = $urandom_range(0, digits_ok ? 62 : 52);
    if (pick < 26) return 8'("a" + pick);
    if (pick < 52) return 8'("A" + pick - 26);
    if (pick == 52) return "_";
    return 8'("0" + pick - 53);
  endfunction

  // The receiver takes results in random bursts, and once, after the first few
  // dozen results, holds off long enough for the lexer to stall its input.
  initial begin : receiver
    int  n;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && checked_count >= 60) begin
        held = 1'b1;
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("c_subset_lexer_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int         r;
    int         len;
    int         i;
    logic [7:0] ch;
    string      single_ops;
    string      pair_heads;
    single_ops = "+-%^;,{}()";
    pair_heads = "/*=<>!&|";

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed text: keyword, name with digits, two-character operator, lone star
    // and lone slash with the following byte pushed back, a high unknown byte, an
    // operator pending at end of text and a line comment cut off by end of text.
    send_text("while(_Z9>=0){x*y/z;}");
    send_item(8'hFF, 1'b0);
    send_text("|");
    send_item(8'h00, 1'b1);
    send_text("//");
    send_item(8'h7F, 1'b1);

    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= QUIET_FROM) quiet <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 6))
          0: send_text("if");
          1: send_text("else");
          2: send_text("for");
          3: send_text("while");
          4: send_text("int");
          5: send_text("char");
          default: send_text("float");
        endcase
      end else if (r < 35) begin
        // Now and then a name around the buffer size, to cover the cut.
        if ($urandom_range(0, 11) == 0) begin
          len = $urandom_range(31, 40);
          long_words++;
        end else begin
          len = $urandom_range(1, 8);
        end
        send_item(word_char(1'b0), 1'b0);
        for (i = 1; i < len; i++) send_item(word_char(1'b1), 1'b0);
      end else if (r < 45) begin
        if ($urandom_range(0, 15) == 0) begin
          len = $urandom_range(31, 36);
          long_words++;
        end else begin
          len = $urandom_range(1, 6);
        end
        for (i = 0; i < len; i++) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (r < 60) begin
        send_item(single_ops[$urandom_range(0, 9)], 1'b0);
      end else if (r < 75) begin
        ch = pair_heads[$urandom_range(0, 7)];
        send_item(ch, 1'b0);
        if ($urandom_range(0, 9) < 6) begin
          case (ch)
            "/": ch = "*";
            "*": ch = "/";
            "<": ch = ($urandom_range(0, 1) != 0) ? "=" : "<";
            ">": ch = ($urandom_range(0, 1) != 0) ? "=" : ">";
            "&": ch = "&";
            "|": ch = "|";
            default: ch = "=";
          endcase
          send_item(ch, 1'b0);
        end
      end else if (r < 80) begin
        send_text("//");
        len = $urandom_range(0, 8);
        for (i = 0; i < len; i++) send_item(8'($urandom_range(32, 126)), 1'b0);
        send_item(8'h0A, 1'b0);
      end else if (r < 85) begin
        if ($urandom_range(0, 1) != 0) send_text("/*");
        else send_text("*/");
      end else if (r < 92) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 95) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) send_item(" ", 1'b0);
      end
      // Half the time fragments abut, so a byte often ends one token and starts another.
      case ($urandom_range(0, 5))
        0: send_item(" ", 1'b0);
        1: send_item(8'h0A, 1'b0);
        2: send_item(8'h09, 1'b0);
        default: ;
      endcase
    end
    send_item(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    // The owed count is registered in the checker, so it lags the last byte taken.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Stimulus: %0d source bytes of keywords, names, numbers, operators and comments,",
             sent_items);
    $display("with %0d over-long words, noise bytes and end marks; %0d results compared.",
             long_words, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("c_subset_lexer_test: done, clean");
    end else begin
      $display("c_subset_lexer_test: done, errors");
    end
    $finish;
  end

endmodule
